/* rtl/rfst_pkg.sv */
// Package for the radio-control frame sync tracker.
// Holds the configuration register map, reset values and the control structs
// that pass between the tracker's modules. Depends on nothing.
`timescale 1ns / 1ps

package rfst_pkg;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SYNC_STEP      = 3'd0,
    REG_SYNC_TOLERANCE = 3'd1,
    REG_RESYNC_TARGET  = 3'd2,
    REG_RESYNC_GAP     = 3'd3,
    REG_HOLD_CHANNEL   = 3'd4,
    REG_HOLD_THRESHOLD = 3'd5
  } cfg_reg_t;

  localparam logic [15:0] SYNC_STEP_RST      = 16'd45;
  localparam logic [7:0]  SYNC_TOLERANCE_RST = 8'd5;
  localparam logic [9:0]  RESYNC_TARGET_RST  = 10'd450;
  localparam logic [7:0]  RESYNC_GAP_RST     = 8'd14;
  localparam logic [3:0]  HOLD_CHANNEL_RST   = 4'd4;
  localparam logic [10:0] HOLD_THRESHOLD_RST = 11'd1600;

  localparam logic [7:0]  GAP_MAX = 8'hFF;

  // Request to the sync tracker for one byte.
  typedef struct packed {
    logic        upd;     // a sync word is complete this byte
    logic        locked;  // block is in normal mode before this byte
    logic [15:0] word;
  } sync_req_t;

  typedef struct packed {
    logic ok;      // word is accepted as a sync word
    logic relock;  // safe zone is left after this byte
  } sync_rsp_t;

  // Control of the receive and replay frame stores for one byte.
  typedef struct packed {
    logic wr_en;  // store the received byte at the current position
    logic copy;   // refresh the whole replay frame from the receive frame
  } store_ctl_t;

endpackage

/* rtl/rfst_sync_track.sv */
// Sync word checker and safe-zone resync counters of the frame sync tracker.
// Keeps the last and expected sync words and the good-sync and gap counters.
// Depends on rfst_pkg.
`timescale 1ns / 1ps

module rfst_sync_track (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [15:0]       cfg_sync_step,
  input  logic [7:0]        cfg_sync_tolerance,
  input  logic [9:0]        cfg_resync_target,
  input  logic [7:0]        cfg_resync_gap,
  input  rfst_pkg::sync_req_t req,
  output rfst_pkg::sync_rsp_t rsp
);
  import rfst_pkg::*;

  logic [15:0] last_sync_r, last_sync_nxt;
  logic [16:0] next_sync_r, next_sync_nxt;
  logic [9:0]  good_cnt_r, good_cnt_nxt;
  logic [7:0]  gap_cnt_r, gap_cnt_nxt;

  logic [17:0] word_ext;
  logic [17:0] tol_ext;
  logic [17:0] next_ext;
  logic        word_ok;
  logic [16:0] accept_next;

  always_comb begin
    word_ext    = {2'b00, req.word};
    tol_ext     = {10'd0, cfg_sync_tolerance};
    next_ext    = {1'b0, next_sync_r};
    // Either a repeat of the last word or strictly inside the window.
    word_ok     = (req.word == last_sync_r) ||
                  (((word_ext + tol_ext) > next_ext) && (word_ext < (next_ext + tol_ext)));
    accept_next = {1'b0, req.word} + {1'b0, cfg_sync_step};

    last_sync_nxt = last_sync_r;
    next_sync_nxt = next_sync_r;
    good_cnt_nxt  = good_cnt_r;
    gap_cnt_nxt   = gap_cnt_r;

    if (req.upd) begin
      if (req.locked) begin
        if (word_ok) begin
          last_sync_nxt = req.word;
          next_sync_nxt = accept_next;
        end else begin
          good_cnt_nxt  = '0;
          gap_cnt_nxt   = '0;
          next_sync_nxt = {1'b0, cfg_sync_step};
        end
      end else begin
        if (word_ok) begin
          last_sync_nxt = req.word;
          next_sync_nxt = accept_next;
          // Gap-spaced syncs, or any at zero count, count; others pull back.
          if ((good_cnt_r == '0) || (gap_cnt_r == cfg_resync_gap)) begin
            good_cnt_nxt = good_cnt_r + 10'd1;
            gap_cnt_nxt  = '0;
          end else begin
            good_cnt_nxt = good_cnt_r - 10'd1;
          end
        end else if (gap_cnt_r != GAP_MAX) begin
          gap_cnt_nxt = gap_cnt_r + 8'd1;
        end
      end
    end

    rsp.ok     = word_ok;
    rsp.relock = req.upd && !req.locked && (good_cnt_nxt >= cfg_resync_target);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_sync_r <= '0;
      next_sync_r <= {1'b0, SYNC_STEP_RST};
      good_cnt_r  <= '0;
      gap_cnt_r   <= '0;
    end else begin
      last_sync_r <= last_sync_nxt;
      next_sync_r <= next_sync_nxt;
      good_cnt_r  <= good_cnt_nxt;
      gap_cnt_r   <= gap_cnt_nxt;
    end
  end

endmodule

/* rtl/rfst_channel_hold.sv */
// Channel level table of the frame sync tracker and the replay freeze test.
// Stores the last level of each channel slot and compares the hold channel.
// Depends on rfst_pkg.
`timescale 1ns / 1ps

module rfst_channel_hold #(
  parameter int unsigned CHANNEL_SLOTS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        wr_en,
  input  logic [3:0]  chan_id,
  input  logic [10:0] chan_level,
  input  logic [3:0]  hold_channel,
  input  logic [10:0] hold_threshold,
  output logic        frozen
);
  import rfst_pkg::*;

  localparam int unsigned SLOT_W = $clog2(CHANNEL_SLOTS);

  logic [10:0] level_r [CHANNEL_SLOTS];

  logic        id_in_range;
  logic        hold_in_range;
  logic [10:0] hold_level;

  always_comb begin
    id_in_range   = ({1'b0, chan_id} < 5'(CHANNEL_SLOTS));
    hold_in_range = ({1'b0, hold_channel} < 5'(CHANNEL_SLOTS));
    // A level written by this same word is already seen by the test.
    if (!hold_in_range) begin
      hold_level = '0;
    end else if (wr_en && id_in_range && (chan_id == hold_channel)) begin
      hold_level = chan_level;
    end else begin
      hold_level = level_r[hold_channel[SLOT_W-1:0]];
    end
    frozen = (hold_level > hold_threshold);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CHANNEL_SLOTS; i++) begin
        level_r[i] <= '0;
      end
    end else if (wr_en && id_in_range) begin
      level_r[chan_id[SLOT_W-1:0]] <= chan_level;
    end
  end

endmodule

/* rtl/rfst_replay_store.sv */
// Receive and replay frame stores of the frame sync tracker.
// The replay frame is kept lazily: an entry written since the last refresh
// reads its saved older copy. Depends on rfst_pkg.
`timescale 1ns / 1ps

module rfst_replay_store #(
  parameter int unsigned FRAME_BYTES = 16
) (
  input  logic                                          clk,
  input  logic                                          rst_n,
  input  logic [$clog2((FRAME_BYTES / 2) * 2)-1:0]      rd_addr,
  input  logic [$clog2((FRAME_BYTES / 2) * 2)-1:0]      cur_addr,
  input  rfst_pkg::store_ctl_t                          ctl,
  input  logic [7:0]                                    wr_data,
  output logic [7:0]                                    replay_byte
);
  import rfst_pkg::*;

  localparam int unsigned FRAME_LEN = (FRAME_BYTES / 2) * 2;

  logic [7:0]           rx_mem [FRAME_LEN];
  logic [7:0]           rp_mem [FRAME_LEN];
  logic [7:0]           rx_rd_r;
  logic [7:0]           rp_rd_r;
  logic [FRAME_LEN-1:0] written_r, written_nxt;
  logic [FRAME_LEN-1:0] dirty_r, dirty_nxt;
  logic [7:0]           rx_cur;

  // The read port always follows the position the next word will use, so
  // the registered data is ready when that word arrives. The write address
  // of a word never equals the position that follows it.
  always_ff @(posedge clk) begin
    rx_rd_r <= rx_mem[rd_addr];
    rp_rd_r <= rp_mem[rd_addr];
    if (ctl.wr_en) begin
      rx_mem[cur_addr] <= wr_data;
    end
    if (ctl.wr_en && !dirty_r[cur_addr]) begin
      rp_mem[cur_addr] <= rx_cur;
    end
  end

  always_comb begin
    rx_cur      = written_r[cur_addr] ? rx_rd_r : 8'h00;
    replay_byte = dirty_r[cur_addr] ? rp_rd_r : rx_cur;

    written_nxt = written_r;
    dirty_nxt   = dirty_r;
    if (ctl.wr_en) begin
      written_nxt[cur_addr] = 1'b1;
      dirty_nxt[cur_addr]   = 1'b1;
    end
    if (ctl.copy) begin
      dirty_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      written_r <= '0;
      dirty_r   <= '0;
    end else begin
      written_r <= written_nxt;
      dirty_r   <= dirty_nxt;
    end
  end

endmodule

/* rtl/rc_frame_sync_tracker.sv */
// Top level of the radio-control frame sync tracker.
// Uses rfst_pkg, rfst_sync_track, rfst_channel_hold and rfst_replay_store.
//
//   Port group | Direction | Handshake        | Word
//   in_*       | input     | in_valid/in_stall   | one received byte
//   out_*      | output    | out_valid/out_stall | transmit byte and decode status
//   cfg_*      | input     | cfg_valid/cfg_ready | register index and data
//
// A byte is taken into the input register, processed and held in the output
// register; one byte per cycle flows through while the output is not stalled.
// The frame stores read at the next frame position into registered data.
// Reset is synchronous and resets control state and configuration, not the
// byte and output data registers or frame memories. A stalled output stalls
// the input register, and the input takes a new byte whenever it drains.
`timescale 1ns / 1ps

module rc_frame_sync_tracker #(
  parameter int unsigned FRAME_BYTES   = 16,
  parameter int unsigned CHANNEL_SLOTS = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [7:0]                      in_rx_byte,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [7:0]                      out_tx_byte,
  output logic                            out_channel_valid,
  output logic [3:0]                      out_channel_id,
  output logic [10:0]                     out_channel_level,
  output logic                            out_frame_done,
  output logic                            out_sync_checked,
  output logic [15:0]                     out_sync_word,
  output logic                            out_locked,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [rfst_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rfst_pkg::CFG_DATA_W-1:0] cfg_data
);
  import rfst_pkg::*;

  localparam int unsigned FRAME_LEN = (FRAME_BYTES / 2) * 2;
  localparam int unsigned POS_W     = $clog2(FRAME_LEN);

  // Configuration registers.
  logic [15:0] sync_step_r;
  logic [7:0]  sync_tolerance_r;
  logic [9:0]  resync_target_r;
  logic [7:0]  resync_gap_r;
  logic [3:0]  hold_channel_r;
  logic [10:0] hold_threshold_r;

  // Input register.
  logic       in_valid_r, in_valid_nxt;
  logic [7:0] rx_r;

  // Tracker state.
  logic             locked_mode_r, locked_mode_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic             second_r, second_nxt;
  logic [7:0]       prev_r, prev_nxt;

  // Output register.
  logic        out_valid_r, out_valid_nxt;
  logic [7:0]  tx_r, tx_nxt;
  logic        cvalid_r, cvalid_nxt;
  logic [3:0]  cid_r, cid_nxt;
  logic [10:0] clevel_r, clevel_nxt;
  logic        fdone_r, fdone_nxt;
  logic        schk_r, schk_nxt;
  logic [15:0] sword_r, sword_nxt;
  logic        olocked_r;

  logic             proc;
  logic             in_accept;
  logic [15:0]      word;
  logic             sync_pos;
  logic [POS_W:0]   pos_inc;
  logic [POS_W-1:0] rd_addr;
  logic [7:0]       replay_byte;
  logic             frozen;
  logic             hold_wr;
  sync_req_t        sync_req;
  sync_rsp_t        sync_rsp;
  store_ctl_t       store_ctl;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_step_r      <= SYNC_STEP_RST;
      sync_tolerance_r <= SYNC_TOLERANCE_RST;
      resync_target_r  <= RESYNC_TARGET_RST;
      resync_gap_r     <= RESYNC_GAP_RST;
      hold_channel_r   <= HOLD_CHANNEL_RST;
      hold_threshold_r <= HOLD_THRESHOLD_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_SYNC_STEP:      sync_step_r      <= cfg_data[15:0];
        REG_SYNC_TOLERANCE: sync_tolerance_r <= cfg_data[7:0];
        REG_RESYNC_TARGET:  resync_target_r  <= cfg_data[9:0];
        REG_RESYNC_GAP:     resync_gap_r     <= cfg_data[7:0];
        REG_HOLD_CHANNEL:   hold_channel_r   <= cfg_data[3:0];
        REG_HOLD_THRESHOLD: hold_threshold_r <= cfg_data[10:0];
        default: ;
      endcase
    end
  end

  // Handshake.
  always_comb begin
    proc          = in_valid_r && (!out_valid_r || !out_stall);
    in_stall      = in_valid_r && !proc;
    in_accept     = in_valid && !in_stall;
    in_valid_nxt  = in_accept ? 1'b1 : (proc ? 1'b0 : in_valid_r);
    out_valid_nxt = proc ? 1'b1 : (out_valid_r && out_stall);
  end

  // Per-byte processing.
  always_comb begin
    word     = {prev_r, rx_r};
    sync_pos = (pos_r[POS_W-1:1] == '0);
    pos_inc  = {1'b0, pos_r} + (POS_W + 1)'(1);

    locked_mode_nxt = locked_mode_r;
    pos_nxt         = pos_r;
    second_nxt      = second_r;
    prev_nxt        = prev_r;

    tx_nxt     = '0;
    cvalid_nxt = 1'b0;
    cid_nxt    = '0;
    clevel_nxt = '0;
    fdone_nxt  = 1'b0;
    schk_nxt   = 1'b0;
    sword_nxt  = '0;

    sync_req.upd    = 1'b0;
    sync_req.locked = locked_mode_r;
    sync_req.word   = word;
    store_ctl.wr_en = 1'b0;
    store_ctl.copy  = 1'b0;
    hold_wr         = 1'b0;

    if (proc) begin
      prev_nxt = rx_r;
      if (locked_mode_r) begin
        tx_nxt          = replay_byte;
        store_ctl.wr_en = 1'b1;
        if (!second_r) begin
          second_nxt = 1'b1;
          pos_nxt    = pos_inc[POS_W-1:0];
        end else begin
          second_nxt = 1'b0;
          if (sync_pos) begin
            schk_nxt     = 1'b1;
            sword_nxt    = word;
            pos_nxt      = POS_W'(2);
            sync_req.upd = 1'b1;
            if (!sync_rsp.ok) begin
              locked_mode_nxt = 1'b0;
            end
          end else begin
            cvalid_nxt = 1'b1;
            cid_nxt    = prev_r[6:3];
            clevel_nxt = {prev_r[2:0], rx_r};
            hold_wr    = 1'b1;
            if (pos_inc >= (POS_W + 1)'(FRAME_LEN)) begin
              fdone_nxt = 1'b1;
              pos_nxt   = '0;
            end else begin
              pos_nxt = pos_inc[POS_W-1:0];
            end
          end
        end
        // Data bytes refresh the replay frame unless the hold channel is high.
        store_ctl.copy = !sync_pos && !frozen;
      end else begin
        tx_nxt = rx_r;
        if (!second_r) begin
          second_nxt = 1'b1;
        end else begin
          second_nxt   = 1'b0;
          schk_nxt     = 1'b1;
          sword_nxt    = word;
          sync_req.upd = 1'b1;
          if (sync_rsp.relock) begin
            locked_mode_nxt = 1'b1;
            pos_nxt         = POS_W'(2);
          end
        end
      end
    end

    rd_addr = rst_n ? pos_nxt : '0;
  end

  rfst_sync_track u_sync (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_sync_step      (sync_step_r),
    .cfg_sync_tolerance (sync_tolerance_r),
    .cfg_resync_target  (resync_target_r),
    .cfg_resync_gap     (resync_gap_r),
    .req                (sync_req),
    .rsp                (sync_rsp)
  );

  rfst_channel_hold #(
    .CHANNEL_SLOTS (CHANNEL_SLOTS)
  ) u_hold (
    .clk            (clk),
    .rst_n          (rst_n),
    .wr_en          (hold_wr),
    .chan_id        (prev_r[6:3]),
    .chan_level     ({prev_r[2:0], rx_r}),
    .hold_channel   (hold_channel_r),
    .hold_threshold (hold_threshold_r),
    .frozen         (frozen)
  );

  rfst_replay_store #(
    .FRAME_BYTES (FRAME_BYTES)
  ) u_store (
    .clk         (clk),
    .rst_n       (rst_n),
    .rd_addr     (rd_addr),
    .cur_addr    (pos_r),
    .ctl         (store_ctl),
    .wr_data     (rx_r),
    .replay_byte (replay_byte)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r    <= 1'b0;
      out_valid_r   <= 1'b0;
      locked_mode_r <= 1'b1;
      pos_r         <= '0;
      second_r      <= 1'b0;
      prev_r        <= '0;
    end else begin
      in_valid_r    <= in_valid_nxt;
      out_valid_r   <= out_valid_nxt;
      locked_mode_r <= locked_mode_nxt;
      pos_r         <= pos_nxt;
      second_r      <= second_nxt;
      prev_r        <= prev_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      rx_r <= in_rx_byte;
    end
    if (proc) begin
      tx_r      <= tx_nxt;
      cvalid_r  <= cvalid_nxt;
      cid_r     <= cid_nxt;
      clevel_r  <= clevel_nxt;
      fdone_r   <= fdone_nxt;
      schk_r    <= schk_nxt;
      sword_r   <= sword_nxt;
      olocked_r <= locked_mode_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_tx_byte       = tx_r;
  assign out_channel_valid = cvalid_r;
  assign out_channel_id    = cid_r;
  assign out_channel_level = clevel_r;
  assign out_frame_done    = fdone_r;
  assign out_sync_checked  = schk_r;
  assign out_sync_word     = sword_r;
  assign out_locked        = olocked_r;

`ifndef SYNTH
  a_chan_locked: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_channel_valid |-> out_locked && !out_sync_checked)
    else $error("channel word reported outside normal mode");

  a_done_chan: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_frame_done |-> out_channel_valid)
    else $error("frame end without a completed channel pair");

  a_pair_align: assert property (@(posedge clk) disable iff (!rst_n)
    locked_mode_r |-> (second_r == pos_r[0]))
    else $error("pair phase out of step with frame position");

  a_relock_pos: assert property (@(posedge clk) disable iff (!rst_n)
    proc && !locked_mode_r |=> !locked_mode_r || ((pos_r == POS_W'(2)) && !second_r))
    else $error("relock did not restart at the first channel byte");
`endif

endmodule
